// File: src/gkca_pkg.sv
// ----------------------------------------------------------------------------
// gkca_pkg
// Shared types, constants and the exp step ratio for the Gaussian kernel
// density accumulator.
// ----------------------------------------------------------------------------
package gkca_pkg;

    // Fixed-point format and exp table geometry
    localparam int FRACTION_BITS     = 16;
    localparam int EXP_TABLE_ENTRIES = 1024;
    localparam int EXP_RANGE         = 16;
    localparam int TAYLOR_TERMS      = 12;

    localparam int EXP_IDX_W     = $clog2(EXP_TABLE_ENTRIES);
    localparam int EXP_W         = FRACTION_BITS + 1;
    localparam int SPAN_LOG2     = $clog2(EXP_RANGE) + FRACTION_BITS;
    localparam int EXP_IDX_SHIFT = SPAN_LOG2 - EXP_IDX_W;

    localparam logic [63:0] EXP_SPAN  = 64'(EXP_RANGE) << FRACTION_BITS;
    localparam logic [63:0] FIXED_ONE = 64'(1) << FRACTION_BITS;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_INV_RES_SQ  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_KERNEL_NORM = 8'd1;
    localparam logic [CFG_DATA_W-1:0]  CFG_RESET_VALUE     = 32'h0001_0000;

    // Step ratio exp(-EXP_RANGE/EXP_TABLE_ENTRIES) in Q30 by a Taylor series
    // of TAYLOR_TERMS + 1 terms, each term derived from the one before
    localparam longint EXP_H   = (longint'(EXP_RANGE) <<< 30) / EXP_TABLE_ENTRIES;
    localparam longint EXP_T0  = longint'(1) <<< 30;
    localparam longint EXP_T1  = ((EXP_T0 * EXP_H) >>> 30) / 1;
    localparam longint EXP_T2  = ((EXP_T1 * EXP_H) >>> 30) / 2;
    localparam longint EXP_T3  = ((EXP_T2 * EXP_H) >>> 30) / 3;
    localparam longint EXP_T4  = ((EXP_T3 * EXP_H) >>> 30) / 4;
    localparam longint EXP_T5  = ((EXP_T4 * EXP_H) >>> 30) / 5;
    localparam longint EXP_T6  = ((EXP_T5 * EXP_H) >>> 30) / 6;
    localparam longint EXP_T7  = ((EXP_T6 * EXP_H) >>> 30) / 7;
    localparam longint EXP_T8  = ((EXP_T7 * EXP_H) >>> 30) / 8;
    localparam longint EXP_T9  = ((EXP_T8 * EXP_H) >>> 30) / 9;
    localparam longint EXP_T10 = ((EXP_T9 * EXP_H) >>> 30) / 10;
    localparam longint EXP_T11 = ((EXP_T10 * EXP_H) >>> 30) / 11;
    localparam longint EXP_T12 = ((EXP_T11 * EXP_H) >>> 30) / 12;
    localparam longint EXP_TAYLOR_SUM = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                      - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                      + EXP_T10 - EXP_T11 + EXP_T12;

    localparam logic [29:0] EXP_Q = 30'(EXP_TAYLOR_SUM);

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [15:0]        atom_mass;
        logic               last_of_node;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] density_sum;
        logic signed [63:0] momentum_sum;
        logic signed [63:0] force_sum;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] inverse_resolution_squared;
        logic [CFG_DATA_W-1:0] kernel_normalization;
    } t_cfg;

    // Request to the shared multiply unit: magnitudes plus sign handling
    typedef struct packed {
        logic        start;
        logic [63:0] a_mag;
        logic [63:0] b_mag;
        logic        neg;
        logic        signed_op;
        logic        shift_f;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
        logic        clip;
    } t_mul_rsp;

    typedef struct packed {
        logic                 en;
        logic [EXP_IDX_W-1:0] addr;
    } t_look_req;

    typedef enum logic {
        EXP_FILL,
        EXP_READY
    } t_exp_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ,
        S_X,
        S_LOOK,
        S_LOOKW,
        S_K1,
        S_K2,
        S_DEN,
        S_DENA,
        S_MOM,
        S_MOMA,
        S_U,
        S_T1,
        S_W,
        S_T2,
        S_VV,
        S_UU,
        S_T3A,
        S_T3B,
        S_NT2,
        S_S1,
        S_S2,
        S_S3,
        S_IN2,
        S_FK,
        S_FA,
        S_EMIT
    } t_step;

endpackage

// File: src/gkca_if.sv
// ----------------------------------------------------------------------------
// gkca_if
// Valid/ready channels of the accumulator: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface gkca_in_if
    import gkca_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gkca_out_if
    import gkca_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gkca_cfg_if
    import gkca_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/gkca_ram.sv
// ----------------------------------------------------------------------------
// gkca_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gkca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/gkca_exp.sv
// ----------------------------------------------------------------------------
// gkca_exp
// Exp table: filled after reset by a rounded Q30 recurrence, one entry per
// cycle, then serves lookups with registered read data.
// ----------------------------------------------------------------------------
module gkca_exp
    import gkca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_look_req        i_look,
    output logic [EXP_W-1:0] o_look_data,
    output logic             o_ready
);

    t_exp_state           r_state;
    t_exp_state           n_state;
    logic [30:0]          r_cur;
    logic [30:0]          n_cur;
    logic [EXP_IDX_W-1:0] r_idx;
    logic [EXP_IDX_W-1:0] n_idx;
    logic [60:0]          prod;
    logic [60:0]          prod_rnd;
    logic                 wr_en;
    logic [EXP_W-1:0]     wr_data;

    // hold fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EXP_FILL;
            r_cur   <= 31'(1) << 30;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_idx   <= n_idx;
        end
    end

    // advance the recurrence and write one entry per cycle while filling
    always_comb begin
        prod     = 61'(r_cur) * 61'(EXP_Q);
        prod_rnd = prod + (61'(1) << 29);
        wr_data  = EXP_W'((r_cur + (31'(1) << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
        n_state  = r_state;
        n_cur    = r_cur;
        n_idx    = r_idx;
        wr_en    = 1'b0;
        unique case (r_state)
            EXP_FILL: begin
                wr_en = 1'b1;
                n_cur = 31'(prod_rnd >> 30);
                n_idx = r_idx + 1'b1;
                if (r_idx == EXP_IDX_W'(EXP_TABLE_ENTRIES - 1)) begin
                    n_state = EXP_READY;
                end
            end
            EXP_READY: begin
                n_state = EXP_READY;
            end
        endcase
    end

    gkca_ram #(
        .WIDTH (EXP_W),
        .DEPTH (EXP_TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (i_look.en),
        .i_rd_addr (i_look.addr),
        .o_rd_data (o_look_data)
    );

    assign o_ready = (r_state == EXP_READY);

endmodule

// File: src/gkca_front.sv
// ----------------------------------------------------------------------------
// gkca_front
// Input side: accepts item beats into a two-entry queue ahead of the
// arithmetic sequencer.
// ----------------------------------------------------------------------------
module gkca_front
    import gkca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_enable,
    gkca_in_if.sink    i_in,
    output t_in_item   o_head,
    output logic       o_head_valid,
    input  logic       i_pop
);

    t_in_item   r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;

    assign i_in.ready   = i_enable && (r_count != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_slot[r_rd_ptr];

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

    // store the accepted beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_in.data;
        end
    end

endmodule

// File: src/gkca_mul.sv
// ----------------------------------------------------------------------------
// gkca_mul
// Shared 64x64 magnitude multiplier: four 32x32 partial products formed in
// turn and accumulated, then an optional right shift by the fraction width,
// saturation and sign.
// ----------------------------------------------------------------------------
module gkca_mul
    import gkca_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_neg;
    logic         r_signed;
    logic         r_shift_f;
    logic [63:0]  r_pp;
    logic [1:0]   r_pos;
    logic [127:0] r_acc;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] shifted;
    logic [63:0]  lim;
    logic         over;
    logic [63:0]  mag_r;

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (!r_busy) begin
            r_busy <= i_req.start;
            r_cnt  <= 3'd0;
        end else begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd5) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[0] ? r_b[63:32] : r_b[31:0];

    // latch operands, form registered partial products, accumulate each in the following cycle
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_req.start) begin
                r_a       <= i_req.a_mag;
                r_b       <= i_req.b_mag;
                r_neg     <= i_req.neg;
                r_signed  <= i_req.signed_op;
                r_shift_f <= i_req.shift_f;
                r_acc     <= '0;
            end
        end else begin
            if (r_cnt < 3'd4) begin
                r_pp  <= 64'(a_part) * 64'(b_part);
                r_pos <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + (128'(r_pp) << {r_pos, 5'b0});
            end
        end
    end

    // shift, saturate to the limit for the sign, apply the sign
    always_comb begin
        shifted = r_shift_f ? (r_acc >> FRACTION_BITS) : r_acc;
        if (!r_signed) begin
            lim = '1;
        end else if (r_neg) begin
            lim = 64'h8000_0000_0000_0000;
        end else begin
            lim = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        over         = (|shifted[127:64]) || (shifted[63:0] > lim);
        mag_r        = over ? lim : shifted[63:0];
        o_rsp.done   = r_busy && (r_cnt == 3'd5);
        o_rsp.result = (r_signed && r_neg) ? (64'd0 - mag_r) : mag_r;
        o_rsp.clip   = r_signed && over;
    end

endmodule

// File: src/gkca_back.sv
// ----------------------------------------------------------------------------
// gkca_back
// Arithmetic sequencer: walks one queued item through the kernel, momentum
// and force terms on the shared multiplier, keeps the saturating sums and
// emits them into the output register at the end of a node.
// ----------------------------------------------------------------------------
module gkca_back
    import gkca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_in_item         i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    output t_look_req        o_look,
    input  logic [EXP_W-1:0] i_look_data,
    output t_mul_req         o_mul_req,
    input  t_mul_rsp         i_mul_rsp,
    gkca_out_if.source       o_out
);

    function automatic logic [63:0] sext32(logic [31:0] a);
        return {{32{a[31]}}, a};
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // saturating signed add; top bit flags a clip
    function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return {1'b1, (s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)};
        end
        return {1'b0, s[63:0]};
    endfunction

    t_step r_step;
    t_step n_step;
    logic  r_wait;
    logic  n_wait;
    logic [1:0] r_dim;
    logic [1:0] n_dim;
    logic [63:0] r_d2, n_d2, r_x, n_x, r_k, n_k;
    logic [EXP_W-1:0] r_e, n_e;
    logic [63:0] r_u, n_u, r_w, n_w, r_t1, n_t1, r_t2, n_t2;
    logic [63:0] r_vv, n_vv, r_uu, n_uu, r_t3, n_t3, r_s, n_s;
    logic [63:0] r_inner, n_inner, r_tmp, n_tmp;
    logic [63:0] r_den, n_den, r_mom, n_mom, r_frc, n_frc;
    logic r_clip, n_clip;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic [31:0] o_d, v_d, f_d;
    logic [63:0] res_r, res_nk;
    logic        op_mul, op_sgn, op_shf;
    logic [63:0] op_a, op_b;
    logic        mul_fin;
    logic [64:0] add_r;

    assign res_r  = 64'(i_cfg.inverse_resolution_squared);
    assign res_nk = 64'(i_cfg.kernel_normalization);

    // select the lane of the current dimension
    always_comb begin
        unique case (r_dim)
            2'd0: begin
                o_d = i_head.offset_x;
                v_d = i_head.velocity_x;
                f_d = i_head.force_x;
            end
            2'd1: begin
                o_d = i_head.offset_y;
                v_d = i_head.velocity_y;
                f_d = i_head.force_y;
            end
            default: begin
                o_d = i_head.offset_z;
                v_d = i_head.velocity_z;
                f_d = i_head.force_z;
            end
        endcase
    end

    // operands of the multiply for each step; issue when not yet waiting
    always_comb begin
        op_mul = 1'b1;
        op_sgn = 1'b1;
        op_shf = 1'b0;
        op_a   = '0;
        op_b   = '0;
        unique case (r_step)
            S_SQ: begin
                op_a   = abs64(sext32(o_d));
                op_b   = abs64(sext32(o_d));
                op_sgn = 1'b0;
            end
            S_X: begin
                op_a   = r_d2 >> FRACTION_BITS;
                op_b   = res_r;
                op_sgn = 1'b0;
                op_shf = 1'b1;
            end
            S_K1: begin
                op_a   = 64'(r_e);
                op_b   = res_nk;
                op_sgn = 1'b0;
                op_shf = 1'b1;
            end
            S_K2: begin
                op_a   = r_k;
                op_b   = 64'(i_head.atom_mass);
                op_sgn = 1'b0;
            end
            S_DEN: begin
                op_a = r_k;
                op_b = FIXED_ONE;
            end
            S_MOM: begin
                op_a = sext32(i_head.velocity_z);
                op_b = r_k;
            end
            S_U: begin
                op_a   = sext32(o_d);
                op_b   = res_r;
                op_shf = 1'b1;
            end
            S_T1: begin
                op_a   = r_u;
                op_b   = sext32(f_d);
                op_shf = 1'b1;
            end
            S_W: begin
                op_a   = sext32(v_d);
                op_b   = res_r;
                op_shf = 1'b1;
            end
            S_T2: begin
                op_a   = r_w;
                op_b   = sext32(v_d);
                op_shf = 1'b1;
            end
            S_VV: begin
                op_a   = sext32(v_d);
                op_b   = sext32(v_d);
                op_shf = 1'b1;
            end
            S_UU: begin
                op_a   = r_u;
                op_b   = r_u;
                op_shf = 1'b1;
            end
            S_T3A: begin
                op_a   = r_vv;
                op_b   = r_uu;
                op_shf = 1'b1;
            end
            S_T3B: begin
                op_a = r_t3;
                op_b = 64'd2;
            end
            S_NT2: begin
                op_a = r_t2;
                op_b = '1;
            end
            S_IN2: begin
                op_a = r_inner;
                op_b = 64'd2;
            end
            S_FK: begin
                op_a = r_inner;
                op_b = r_k;
            end
            default: begin
                op_mul = 1'b0;
            end
        endcase
        o_mul_req.start     = op_mul && !r_wait;
        o_mul_req.a_mag     = (op_sgn && op_a[63]) ? (64'd0 - op_a) : op_a;
        o_mul_req.b_mag     = (op_sgn && op_b[63]) ? (64'd0 - op_b) : op_b;
        o_mul_req.neg       = op_sgn && (op_a[63] ^ op_b[63]);
        o_mul_req.signed_op = op_sgn;
        o_mul_req.shift_f   = op_shf;
    end

    // next step and datapath updates
    always_comb begin
        n_step      = r_step;
        n_wait      = r_wait;
        n_dim       = r_dim;
        n_d2        = r_d2;
        n_x         = r_x;
        n_e         = r_e;
        n_k         = r_k;
        n_u         = r_u;
        n_w         = r_w;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_vv        = r_vv;
        n_uu        = r_uu;
        n_t3        = r_t3;
        n_s         = r_s;
        n_inner     = r_inner;
        n_tmp       = r_tmp;
        n_den       = r_den;
        n_mom       = r_mom;
        n_frc       = r_frc;
        n_clip      = r_clip;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        add_r       = '0;
        mul_fin     = 1'b0;
        o_pop       = 1'b0;
        o_look.en   = 1'b0;
        o_look.addr = EXP_IDX_W'(r_x >> EXP_IDX_SHIFT);

        // drop the result beat once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // issue a multiply, then wait for it
        if (op_mul) begin
            if (!r_wait) begin
                n_wait = 1'b1;
            end else if (i_mul_rsp.done) begin
                n_wait  = 1'b0;
                mul_fin = 1'b1;
                if (i_mul_rsp.clip) begin
                    n_clip = 1'b1;
                end
            end
        end

        unique case (r_step)
            S_IDLE: begin
                if (i_head_valid) begin
                    n_step  = S_SQ;
                    n_dim   = 2'd0;
                    n_d2    = '0;
                    n_inner = '0;
                end
            end
            S_SQ: begin
                if (mul_fin) begin
                    n_d2 = r_d2 + i_mul_rsp.result;
                    if (r_dim == 2'd2) begin
                        n_dim  = 2'd0;
                        n_step = S_X;
                    end else begin
                        n_dim = r_dim + 2'd1;
                    end
                end
            end
            S_X: begin
                if (mul_fin) begin
                    n_x    = i_mul_rsp.result;
                    n_step = S_LOOK;
                end
            end
            S_LOOK: begin
                o_look.en = 1'b1;
                n_step    = S_LOOKW;
            end
            S_LOOKW: begin
                n_e    = (r_x >= EXP_SPAN) ? '0 : i_look_data;
                n_step = S_K1;
            end
            S_K1: begin
                if (mul_fin) begin
                    n_k    = i_mul_rsp.result;
                    n_step = S_K2;
                end
            end
            S_K2: begin
                if (mul_fin) begin
                    n_k    = i_mul_rsp.result;
                    n_step = S_DEN;
                end
            end
            S_DEN: begin
                if (mul_fin) begin
                    n_tmp  = i_mul_rsp.result;
                    n_step = S_DENA;
                end
            end
            S_DENA: begin
                add_r  = sat_add(r_den, r_tmp);
                n_den  = add_r[63:0];
                n_clip = r_clip | add_r[64];
                n_step = S_MOM;
            end
            S_MOM: begin
                if (mul_fin) begin
                    n_tmp  = i_mul_rsp.result;
                    n_step = S_MOMA;
                end
            end
            S_MOMA: begin
                add_r  = sat_add(r_mom, r_tmp);
                n_mom  = add_r[63:0];
                n_clip = r_clip | add_r[64];
                n_step = S_U;
            end
            S_U: begin
                if (mul_fin) begin
                    n_u    = i_mul_rsp.result;
                    n_step = S_T1;
                end
            end
            S_T1: begin
                if (mul_fin) begin
                    n_t1   = i_mul_rsp.result;
                    n_step = S_W;
                end
            end
            S_W: begin
                if (mul_fin) begin
                    n_w    = i_mul_rsp.result;
                    n_step = S_T2;
                end
            end
            S_T2: begin
                if (mul_fin) begin
                    n_t2   = i_mul_rsp.result;
                    n_step = S_VV;
                end
            end
            S_VV: begin
                if (mul_fin) begin
                    n_vv   = i_mul_rsp.result;
                    n_step = S_UU;
                end
            end
            S_UU: begin
                if (mul_fin) begin
                    n_uu   = i_mul_rsp.result;
                    n_step = S_T3A;
                end
            end
            S_T3A: begin
                if (mul_fin) begin
                    n_t3   = i_mul_rsp.result;
                    n_step = S_T3B;
                end
            end
            S_T3B: begin
                if (mul_fin) begin
                    n_t3   = i_mul_rsp.result;
                    n_step = S_NT2;
                end
            end
            S_NT2: begin
                if (mul_fin) begin
                    n_t2   = i_mul_rsp.result;
                    n_step = S_S1;
                end
            end
            S_S1: begin
                add_r  = sat_add(r_t1, r_t2);
                n_s    = add_r[63:0];
                n_clip = r_clip | add_r[64];
                n_step = S_S2;
            end
            S_S2: begin
                add_r  = sat_add(r_s, r_t3);
                n_s    = add_r[63:0];
                n_clip = r_clip | add_r[64];
                n_step = S_S3;
            end
            S_S3: begin
                add_r   = sat_add(r_inner, r_s);
                n_inner = add_r[63:0];
                n_clip  = r_clip | add_r[64];
                if (r_dim == 2'd2) begin
                    n_dim  = 2'd0;
                    n_step = S_IN2;
                end else begin
                    n_dim  = r_dim + 2'd1;
                    n_step = S_U;
                end
            end
            S_IN2: begin
                if (mul_fin) begin
                    n_inner = i_mul_rsp.result;
                    n_step  = S_FK;
                end
            end
            S_FK: begin
                if (mul_fin) begin
                    n_tmp  = i_mul_rsp.result;
                    n_step = S_FA;
                end
            end
            S_FA: begin
                add_r  = sat_add(r_frc, r_tmp);
                n_frc  = add_r[63:0];
                n_clip = r_clip | add_r[64];
                if (i_head.last_of_node) begin
                    n_step = S_EMIT;
                end else begin
                    o_pop  = 1'b1;
                    n_step = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid        = 1'b1;
                    n_out.density_sum  = r_den;
                    n_out.momentum_sum = r_mom;
                    n_out.force_sum    = r_frc;
                    n_out.saturated    = r_clip;
                    n_den              = '0;
                    n_mom              = '0;
                    n_frc              = '0;
                    n_clip             = 1'b0;
                    o_pop              = 1'b1;
                    n_step             = S_IDLE;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_step <= n_step;
            r_wait <= n_wait;
        end
    end

    // accumulators, flag and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den       <= '0;
            r_mom       <= '0;
            r_frc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_dim       <= 2'd0;
        end else begin
            r_den       <= n_den;
            r_mom       <= n_mom;
            r_frc       <= n_frc;
            r_clip      <= n_clip;
            r_out_valid <= n_out_valid;
            r_dim       <= n_dim;
        end
    end

    // working values
    always_ff @(posedge i_clk) begin
        r_d2    <= n_d2;
        r_x     <= n_x;
        r_e     <= n_e;
        r_k     <= n_k;
        r_u     <= n_u;
        r_w     <= n_w;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_vv    <= n_vv;
        r_uu    <= n_uu;
        r_t3    <= n_t3;
        r_s     <= n_s;
        r_inner <= n_inner;
        r_tmp   <= n_tmp;
        r_out   <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// File: src/gaussian_kernel_coarse_grain_accumulator.sv
// ----------------------------------------------------------------------------
// gaussian_kernel_coarse_grain_accumulator
// Deposits atom contributions onto grid nodes with a table-based Gaussian
// kernel. After reset the block fills its exp table entry by entry and
// accepts no item until that is done; configuration writes are taken at any
// time. Each item then runs 37 products one after the other in the back end
// on a single shared 64x64 multiplier; the other steps do saturating adds
// and the table read. A two-entry queue takes the next item while one is
// being worked, and the result register holds a finished node's sums while
// the next node proceeds. Sums are signed Q32.32 and saturate; the saturated
// flag reports any clip of a signed product or sum within the node.
// ----------------------------------------------------------------------------
module gaussian_kernel_coarse_grain_accumulator
    import gkca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gkca_in_if.sink     i_in,
    gkca_out_if.source  o_out,
    gkca_cfg_if.sink    i_cfg
);

    t_cfg             r_cfg;
    t_in_item         head;
    logic             head_valid;
    logic             pop;
    logic             table_ready;
    t_look_req        look;
    logic [EXP_W-1:0] look_data;
    t_mul_req         mul_req;
    t_mul_rsp         mul_rsp;

    // configuration registers; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_resolution_squared <= CFG_RESET_VALUE;
            r_cfg.kernel_normalization       <= CFG_RESET_VALUE;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_IDX_INV_RES_SQ) begin
                r_cfg.inverse_resolution_squared <= i_cfg.data;
            end else if (i_cfg.index == CFG_IDX_KERNEL_NORM) begin
                r_cfg.kernel_normalization <= i_cfg.data;
            end
        end
    end

    gkca_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (table_ready),
        .i_in         (i_in),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    gkca_exp u_exp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_look      (look),
        .o_look_data (look_data),
        .o_ready     (table_ready)
    );

    gkca_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    gkca_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_look       (look),
        .i_look_data  (look_data),
        .o_mul_req    (mul_req),
        .i_mul_rsp    (mul_rsp),
        .o_out        (o_out)
    );

endmodule
